// File: rtl/ppid_pkg.sv
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared types, widths, register codes and reset values of the positional
// PID controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppid_pkg;

	// default parameter values
	localparam int SAMPLE_WIDTH_DEF       = 16;
	localparam int GAIN_FRACTION_BITS_DEF = 8;

	// fixed field widths
	localparam int GAIN_W     = 16;
	localparam int ILIM_W     = 24;
	localparam int OLIM_W     = 31;
	localparam int SUM_W      = 25;
	localparam int DRIVE_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_GAIN_P    = 3'd1,
		REG_GAIN_I    = 3'd2,
		REG_GAIN_D    = 3'd3,
		REG_INT_LIMIT = 3'd4,
		REG_OUT_LIMIT = 3'd5
	} reg_idx_t;

	// controller modes
	localparam logic MODE_PID = 1'b0;
	localparam logic MODE_PD  = 1'b1;

	// reset values
	localparam logic [ILIM_W-1:0] ILIM_RST = {ILIM_W{1'b1}};
	localparam logic [OLIM_W-1:0] OLIM_RST = {OLIM_W{1'b1}};

	typedef struct packed {
		logic              mode;
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
		logic [ILIM_W-1:0] integral_limit;
		logic [OLIM_W-1:0] output_limit;
	} cfg_t;

endpackage

// File: rtl/positional_pid_with_clamps_unit.sv
// ----------------------------------------------------------------------------
// positional_pid_with_clamps_unit
// Path: an accepted sample loads the input register; one combinational PID
//   pass then loads the result register once it is free or draining.
// Throughput: 1 item per cycle unless the output stalls; the error sum (in
//   PID mode) and prior error update in the same pass, so the result
//   register sets the rate.
// Reset: asynchronous, clears state to zero, gains to 0, limits to maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_pid_with_clamps_unit import ppid_pkg::*; #(
	parameter int SAMPLE_WIDTH       = SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] setpoint,
	input  logic signed [SAMPLE_WIDTH-1:0] measured,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [DRIVE_W-1:0]      drive,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data
);

	cfg_t cfg;

	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] setpoint_s1;
	logic signed [SAMPLE_WIDTH-1:0] measured_s1;
	logic                           out_valid_q;
	logic signed [DRIVE_W-1:0]      drive_q;
	logic signed [DRIVE_W-1:0]      drive_next;
	logic                           advance;

	ppid_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ppid_datapath #(
		.SAMPLE_WIDTH       (SAMPLE_WIDTH),
		.GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.setpoint_s1 (setpoint_s1),
		.measured_s1 (measured_s1),
		.cfg         (cfg),
		.drive_next  (drive_next)
	);

	// item moves into the result register when that register is free or draining
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			setpoint_s1 <= setpoint;
			measured_s1 <= measured;
		end
		if (advance)
			drive_q <= drive_next;
	end

	logic signed [DRIVE_W-1:0] olim_chk;
	assign olim_chk = $signed({{(DRIVE_W-OLIM_W){1'b0}}, cfg.output_limit});

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item lost from input stage");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid && (drive == $past(drive_next)))
		else $error("result register missed an item");

	a_drive_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive <= olim_chk) && (drive >= -olim_chk))
		else $error("drive beyond output limit");

endmodule

// File: rtl/ppid_cfg_regs.sv
// ----------------------------------------------------------------------------
// ppid_cfg_regs
// Configuration register file; writes are taken every cycle, unknown
// indexes are dropped and value bits above each register's width ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppid_cfg_regs import ppid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= MODE_PID;
			cfg_q.gain_p         <= '0;
			cfg_q.gain_i         <= '0;
			cfg_q.gain_d         <= '0;
			cfg_q.integral_limit <= ILIM_RST;
			cfg_q.output_limit   <= OLIM_RST;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:      cfg_q.mode           <= cfg_data[0];
				REG_GAIN_P:    cfg_q.gain_p         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:    cfg_q.gain_i         <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:    cfg_q.gain_d         <= cfg_data[GAIN_W-1:0];
				REG_INT_LIMIT: cfg_q.integral_limit <= cfg_data[ILIM_W-1:0];
				REG_OUT_LIMIT: cfg_q.output_limit   <= cfg_data[OLIM_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/ppid_datapath.sv
// ----------------------------------------------------------------------------
// ppid_datapath
// One-pass PID arithmetic: error, clamped integral, three gain products,
// floor shift and output clamp. Holds prior error and error sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppid_datapath import ppid_pkg::*; #(
	parameter int SAMPLE_WIDTH       = SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  logic signed [SAMPLE_WIDTH-1:0] setpoint_s1,
	input  logic signed [SAMPLE_WIDTH-1:0] measured_s1,
	input  cfg_t                           cfg,
	output logic signed [DRIVE_W-1:0]      drive_next
);

	localparam int E_W   = SAMPLE_WIDTH + 1;
	localparam int DE_W  = SAMPLE_WIDTH + 2;
	localparam int ACC_W = ((E_W > SUM_W) ? E_W : SUM_W) + 1;
	localparam int MAX_W = (DE_W > SUM_W) ? DE_W : SUM_W;
	localparam int RAW_W = GAIN_W + MAX_W + 3;

	logic signed [E_W-1:0]   prior_error_q;
	logic signed [SUM_W-1:0] error_sum_q;

	logic signed [E_W-1:0]   err;
	logic signed [DE_W-1:0]  derr;
	logic signed [ACC_W-1:0] sum_raw;
	logic signed [ACC_W-1:0] sum_cl;
	logic signed [ACC_W-1:0] ilim_x;
	logic signed [SUM_W-1:0] sum_next;
	logic signed [RAW_W-1:0] prod_p;
	logic signed [RAW_W-1:0] prod_i;
	logic signed [RAW_W-1:0] prod_d;
	logic signed [RAW_W-1:0] raw;
	logic signed [RAW_W-1:0] shifted;
	logic signed [RAW_W-1:0] olim_x;
	logic signed [RAW_W-1:0] drive_cl;

	always_comb begin
		err  = $signed({setpoint_s1[SAMPLE_WIDTH-1], setpoint_s1})
		     - $signed({measured_s1[SAMPLE_WIDTH-1], measured_s1});
		derr = $signed({err[E_W-1], err}) - $signed({prior_error_q[E_W-1], prior_error_q});

		// integral: add then clamp to +/- limit
		sum_raw = $signed({{(ACC_W-SUM_W){error_sum_q[SUM_W-1]}}, error_sum_q})
		        + $signed({{(ACC_W-E_W){err[E_W-1]}}, err});
		ilim_x  = $signed({{(ACC_W-ILIM_W){1'b0}}, cfg.integral_limit});
		if (sum_raw > ilim_x)
			sum_cl = ilim_x;
		else if (sum_raw < -ilim_x)
			sum_cl = -ilim_x;
		else
			sum_cl = sum_raw;
		sum_next = sum_cl[SUM_W-1:0];

		prod_p = $signed({{(RAW_W-GAIN_W){1'b0}}, cfg.gain_p})
		       * $signed({{(RAW_W-E_W){err[E_W-1]}}, err});
		prod_d = $signed({{(RAW_W-GAIN_W){1'b0}}, cfg.gain_d})
		       * $signed({{(RAW_W-DE_W){derr[DE_W-1]}}, derr});
		prod_i = $signed({{(RAW_W-GAIN_W){1'b0}}, cfg.gain_i})
		       * $signed({{(RAW_W-SUM_W){sum_next[SUM_W-1]}}, sum_next});
		if (cfg.mode == MODE_PD)
			prod_i = '0;

		raw     = prod_p + prod_i + prod_d;
		shifted = raw >>> GAIN_FRACTION_BITS;   // floor toward minus infinity

		olim_x = $signed({{(RAW_W-OLIM_W){1'b0}}, cfg.output_limit});
		if (shifted > olim_x)
			drive_cl = olim_x;
		else if (shifted < -olim_x)
			drive_cl = -olim_x;
		else
			drive_cl = shifted;
		drive_next = drive_cl[DRIVE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_error_q <= '0;
			error_sum_q   <= '0;
		end else if (advance) begin
			prior_error_q <= err;
			if (cfg.mode == MODE_PID)
				error_sum_q <= sum_next;
		end
	end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional PID/PD controller: a directed table
// of register writes and samples, then phases of random settings with
// tracking and noise samples, each drive checked against a table value or an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import ppid_pkg::*;

	localparam int SW          = SAMPLE_WIDTH_DEF;
	localparam int FRAC        = GAIN_FRACTION_BITS_DEF;
	localparam int SETTLE_CYC  = 4;
	localparam int HOLD_CYC    = 60;
	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 50;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		bit                     is_cfg;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic signed [SW-1:0]   sp;
		logic signed [SW-1:0]   ms;
		bit                     has_want;
		logic signed [DRIVE_W-1:0] want;
	} row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [SW-1:0]      setpoint;
	logic signed [SW-1:0]      measured;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [DRIVE_W-1:0] drive;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	positional_pid_with_clamps_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.setpoint  (setpoint),
		.measured  (measured),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// controller model state
	cfg_t   ctl_cfg;
	longint ctl_prior_err;
	longint ctl_err_sum;

	logic signed [DRIVE_W-1:0] exp_drive_q[$];
	logic signed [DRIVE_W-1:0] mon_want;
	row_t dir_tab[$];

	int n_items;
	int n_writes;
	int n_checked;
	int n_bad;
	bit hold_req = 0;
	bit no_idle  = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d drives still pending", exp_drive_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// one controller pass; updates the model state
	function automatic logic signed [DRIVE_W-1:0] next_drive(logic signed [SW-1:0] sp,
			logic signed [SW-1:0] ms);
		longint e;
		longint de;
		longint raw;
		longint q;
		e   = longint'(sp) - longint'(ms);
		de  = e - ctl_prior_err;
		raw = longint'(ctl_cfg.gain_p) * e + longint'(ctl_cfg.gain_d) * de;
		if (ctl_cfg.mode == MODE_PID) begin
			ctl_err_sum = clamp_mag(ctl_err_sum + e, longint'(ctl_cfg.integral_limit));
			raw += longint'(ctl_cfg.gain_i) * ctl_err_sum;
		end
		q = clamp_mag(raw >>> FRAC, longint'(ctl_cfg.output_limit));
		ctl_prior_err = e;
		return q[DRIVE_W-1:0];
	endfunction

	function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = d;
		return r;
	endfunction

	function automatic row_t item_row(logic signed [SW-1:0] sp, logic signed [SW-1:0] ms,
			bit has_want, logic signed [DRIVE_W-1:0] want);
		row_t r;
		r = '0;
		r.sp       = sp;
		r.ms       = ms;
		r.has_want = has_want;
		r.want     = want;
		return r;
	endfunction

	// value in the low w bits, random junk above
	function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int w);
		logic [CFG_DATA_W-1:0] m;
		m = (32'd1 << w) - 32'd1;
		return ($urandom & ~m) | (v & m);
	endfunction

	function automatic logic signed [SW-1:0] rand_sample();
		int v;
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return '0;
			3: begin
				v = $urandom_range(0, 200);
				return SW'(v - 100);
			end
			default: return SW'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 32'hFFFF;
			2: return $urandom_range(0, 65535);
			default: return $urandom_range(0, 1023);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE:      ctl_cfg.mode = d[0];
			REG_GAIN_P:    ctl_cfg.gain_p = d[GAIN_W-1:0];
			REG_GAIN_I:    ctl_cfg.gain_i = d[GAIN_W-1:0];
			REG_GAIN_D:    ctl_cfg.gain_d = d[GAIN_W-1:0];
			REG_INT_LIMIT: ctl_cfg.integral_limit = d[ILIM_W-1:0];
			REG_OUT_LIMIT: ctl_cfg.output_limit = d[OLIM_W-1:0];
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
	endtask

	// called at a falling edge; returns at the falling edge after accept
	task automatic send_item(input logic signed [SW-1:0] sp, input logic signed [SW-1:0] ms,
			input bit has_want, input logic signed [DRIVE_W-1:0] want);
		logic signed [DRIVE_W-1:0] pred;
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 22) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		end
		in_valid = 1'b1;
		setpoint = sp;
		measured = ms;
		do @(posedge clk); while (!in_ready);
		pred = next_drive(sp, ms);
		exp_drive_q.push_back(has_want ? want : pred);
		n_items++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (exp_drive_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic set_phase_cfg(input int p);
		logic [CFG_DATA_W-1:0] md;
		logic [CFG_DATA_W-1:0] il;
		logic [CFG_DATA_W-1:0] ol;
		md = (p == 0) ? 32'(MODE_PID) : (p == 1) ? 32'(MODE_PD) : $urandom_range(0, 1);
		case ($urandom_range(0, 3))
			0: il = 0;
			1: il = 32'(ILIM_RST);
			2: il = $urandom_range(0, 1000);
			default: il = $urandom;
		endcase
		case ($urandom_range(0, 3))
			0: ol = 32'(OLIM_RST);
			1: ol = $urandom_range(0, 100000);
			2: ol = $urandom_range(0, 255);
			default: ol = $urandom;
		endcase
		if (p == 0) begin
			il = 32'(ILIM_RST);
			ol = 32'(OLIM_RST);
		end else if (p == 1) begin
			il = 0;
		end else if (p == N_PHASES - 1) begin
			ol = 0;
		end
		write_reg(REG_MODE, with_junk(md, 1));
		write_reg(REG_GAIN_P, with_junk(p < 2 ? 32'hFFFF : pick_gain(), GAIN_W));
		write_reg(REG_GAIN_I, with_junk(p < 2 ? 32'hFFFF : pick_gain(), GAIN_W));
		write_reg(REG_GAIN_D, with_junk(p < 2 ? 32'hFFFF : pick_gain(), GAIN_W));
		write_reg(REG_INT_LIMIT, with_junk(il, ILIM_W));
		write_reg(REG_OUT_LIMIT, with_junk(ol, OLIM_W));
		if ($urandom_range(0, 2) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
		cfg_valid = 1'b0;
	endtask

	// receiver: random stalls, always ready in no-idle phases, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYC) @(negedge clk);
				hold_req = 1'b0;
			end else if (no_idle) begin
				out_ready = 1'b1;
			end else begin
				out_ready = ($urandom_range(0, 99) >= 22);
			end
		end
	end

	always @(posedge clk) begin : drive_check
		if (arst_n && out_valid && out_ready) begin
			if (exp_drive_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected drive %0d with nothing pending", drive);
			end else begin
				mon_want = exp_drive_q.pop_front();
				n_checked++;
				if (drive !== mon_want) begin
					n_bad++;
					if (n_bad <= 10)
						$display("drive mismatch: expected %0d, got %0d", mon_want, drive);
				end
			end
		end
	end

	initial begin : stim
		row_t r;
		int p;
		int i;
		int tmp;
		int noise;
		bit in_cfg;
		logic signed [SW-1:0] sp;
		logic signed [SW-1:0] ms;
		logic signed [SW-1:0] sp_hold;
		logic signed [SW-1:0] ms_track;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		setpoint  = '0;
		measured  = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		n_items   = 0;
		n_writes  = 0;
		n_checked = 0;
		n_bad     = 0;
		ctl_cfg   = '{mode: MODE_PID, gain_p: '0, gain_i: '0, gain_d: '0,
			integral_limit: ILIM_RST, output_limit: OLIM_RST};
		ctl_prior_err = 0;
		ctl_err_sum   = 0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero gains after reset
		dir_tab.push_back(item_row(16'sh7FFF, 16'sh8000, 1, 0));
		dir_tab.push_back(item_row(16'sh8000, 16'sh7FFF, 1, 0));
		// PD, unity P set with junk above the field, spare index ignored
		dir_tab.push_back(cfg_row(REG_MODE, 32'hFFFF_FFFF));
		dir_tab.push_back(cfg_row(REG_GAIN_P, 32'hABCD_0100));
		dir_tab.push_back(cfg_row(REG_SPARE_A, 32'hFFFF_FFFF));
		dir_tab.push_back(item_row(100, 30, 1, 70));
		dir_tab.push_back(item_row(16'sh8000, 16'sh7FFF, 1, -65535));
		dir_tab.push_back(item_row(5, 5, 1, 0));
		// output limit zero, then small
		dir_tab.push_back(cfg_row(REG_GAIN_P, 32'h0000_FFFF));
		dir_tab.push_back(cfg_row(REG_OUT_LIMIT, 32'h0));
		dir_tab.push_back(item_row(16'sh7FFF, 16'sh8000, 1, 0));
		dir_tab.push_back(cfg_row(REG_OUT_LIMIT, 32'd1000));
		dir_tab.push_back(item_row(16'sh7FFF, 16'sh8000, 1, 1000));
		dir_tab.push_back(item_row(16'sh8000, 16'sh7FFF, 1, -1000));
		// integral path: limit zero pins the sum, then a lowered limit clamps it
		dir_tab.push_back(cfg_row(REG_MODE, 32'h0));
		dir_tab.push_back(cfg_row(REG_GAIN_P, 32'h0));
		dir_tab.push_back(cfg_row(REG_GAIN_I, 32'h0100));
		dir_tab.push_back(cfg_row(REG_INT_LIMIT, 32'h0));
		dir_tab.push_back(cfg_row(REG_OUT_LIMIT, 32'hFFFF_FFFF));
		dir_tab.push_back(item_row(1000, 0, 1, 0));
		dir_tab.push_back(cfg_row(REG_INT_LIMIT, 32'hFFFF_FFFF));
		dir_tab.push_back(item_row(1000, 0, 1, 1000));
		dir_tab.push_back(cfg_row(REG_INT_LIMIT, 32'd300));
		dir_tab.push_back(item_row(10, 0, 1, 300));
		// PD step must leave the sum alone
		dir_tab.push_back(cfg_row(REG_MODE, 32'(MODE_PD)));
		dir_tab.push_back(item_row(-20000, 0, 1, 0));
		dir_tab.push_back(cfg_row(REG_MODE, 32'(MODE_PID)));
		dir_tab.push_back(item_row(0, 0, 1, 300));
		// derivative on the error step
		dir_tab.push_back(cfg_row(REG_GAIN_I, 32'h0));
		dir_tab.push_back(cfg_row(REG_GAIN_D, 32'h0100));
		dir_tab.push_back(item_row(50, 0, 1, 50));
		dir_tab.push_back(item_row(20, 0, 1, -30));
		// half gain: shift floors toward minus infinity
		dir_tab.push_back(cfg_row(REG_GAIN_D, 32'h0));
		dir_tab.push_back(cfg_row(REG_GAIN_P, 32'h0080));
		dir_tab.push_back(item_row(-3, 0, 1, -2));
		dir_tab.push_back(item_row(3, 0, 1, 1));
		// all gains and limits at maximum
		dir_tab.push_back(cfg_row(REG_GAIN_P, 32'hFFFF));
		dir_tab.push_back(cfg_row(REG_GAIN_I, 32'hFFFF));
		dir_tab.push_back(cfg_row(REG_GAIN_D, 32'hFFFF));
		dir_tab.push_back(cfg_row(REG_INT_LIMIT, 32'h00FF_FFFF));
		dir_tab.push_back(cfg_row(REG_OUT_LIMIT, 32'h7FFF_FFFF));
		dir_tab.push_back(item_row(16'sh7FFF, 16'sh8000, 0, 0));
		dir_tab.push_back(item_row(16'sh8000, 16'sh7FFF, 0, 0));
		dir_tab.push_back(item_row(16'sh7FFF, 16'sh8000, 0, 0));
		dir_tab.push_back(cfg_row(REG_SPARE_B, 32'h1234_5678));
		dir_tab.push_back(item_row(0, 0, 0, 0));

		in_cfg = 0;
		foreach (dir_tab[k]) begin
			r = dir_tab[k];
			if (r.is_cfg) begin
				if (!in_cfg)
					wait_idle();
				write_reg(r.idx, r.data);
				in_cfg = 1;
			end else begin
				if (in_cfg) begin
					cfg_valid = 1'b0;
					in_cfg = 0;
				end
				send_item(r.sp, r.ms, r.has_want, r.want);
			end
		end

		sp_hold  = rand_sample();
		ms_track = '0;
		for (p = 0; p < N_PHASES; p++) begin
			wait_idle();
			no_idle = (p == 3);
			set_phase_cfg(p);
			if (p == 2)
				hold_req = 1'b1;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 5 && i == PHASE_ITEMS / 2)
					wait_idle();
				if ($urandom_range(0, 9) == 0)
					sp_hold = rand_sample();
				if ($urandom_range(0, 99) < 30) begin
					sp = rand_sample();
					ms = rand_sample();
				end else begin
					// measurement closing in on the held setpoint, with a bit of noise
					noise = $urandom_range(0, 16);
					tmp = int'(ms_track) + ((int'(sp_hold) - int'(ms_track)) >>> 2) + noise - 8;
					if (tmp > 32767) tmp = 32767;
					if (tmp < -32768) tmp = -32768;
					ms_track = SW'(tmp);
					sp = sp_hold;
					ms = ms_track;
				end
				send_item(sp, ms, 0, 0);
			end
		end
		no_idle = 1'b0;
		wait_idle();

		$display("ran %0d samples over %0d register writes, %0d drives checked, %0d bad",
			n_items, n_writes, n_checked, n_bad);
		$display("covered PID and PD modes, zero and full limits, output hold-off and drains");
		if (n_bad == 0 && exp_drive_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/ppid_pkg.sv
rtl/ppid_cfg_regs.sv
rtl/ppid_datapath.sv
rtl/positional_pid_with_clamps_unit.sv
sim/tb_top.sv
